@@ hw/rtl/ptcl_pkg.sv @@
// ----------------------------------------------------------------------------
// ptcl_pkg
// Shared types and constants of the PI torque current loop: register map,
// configuration bundle, unit status and fixed-point limits.
// ----------------------------------------------------------------------------
package ptcl_pkg;

   // fixed-point limits (Q16.16 unless noted)
   localparam logic [16:0] Q_ONE       = 17'd65536;
   localparam logic [19:0] CURRENT_MAX = 20'd655360;
   localparam logic [47:0] INTEG_MAX   = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] INTEG_MIN   = 48'h8000_0000_0000;

   // multiplier works in 16-bit digits of operand B
   localparam int MUL_DIGIT = 16;
   localparam int MUL_STEPS = 3;
   // divider: 36-bit dividend, one quotient bit per step
   localparam int DIV_STEPS = 36;

   typedef enum logic [2:0] {
      REG_PROP_GAIN       = 3'd0,
      REG_INTEG_GAIN      = 3'd1,
      REG_SENSE_OFFSET    = 3'd2,
      REG_SENSE_SCALE     = 3'd3,
      REG_TORQUE_CONSTANT = 3'd4,
      REG_FILTER_RATE     = 3'd5,
      REG_SPEED_LIMIT     = 3'd6,
      REG_ANGLE_PER_PULSE = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [30:0] prop_gain;
      logic [30:0] integ_gain;
      logic [11:0] sense_offset;
      logic [23:0] sense_scale;
      logic [23:0] torque_constant;
      logic [16:0] filter_rate;
      logic [31:0] speed_limit;
      logic [19:0] angle_per_pulse;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      prop_gain:       31'd10884219,
      integ_gain:      31'd1714506957,
      sense_offset:    12'd373,
      sense_scale:     24'd899809,
      torque_constant: 24'd16548,
      filter_rate:     17'd1440,
      speed_limit:     32'd50000,
      angle_per_pulse: 20'd13083
   };

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

@@ hw/rtl/ptcl_csr.sv @@
// ----------------------------------------------------------------------------
// ptcl_csr
// Configuration register file; one write per accepted csr request.
// ----------------------------------------------------------------------------
module ptcl_csr
   import ptcl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_PROP_GAIN:       cfg_ff.prop_gain       <= csr_wdata[30:0];
            REG_INTEG_GAIN:      cfg_ff.integ_gain      <= csr_wdata[30:0];
            REG_SENSE_OFFSET:    cfg_ff.sense_offset    <= csr_wdata[11:0];
            REG_SENSE_SCALE:     cfg_ff.sense_scale     <= csr_wdata[23:0];
            REG_TORQUE_CONSTANT: cfg_ff.torque_constant <= csr_wdata[23:0];
            REG_FILTER_RATE:     cfg_ff.filter_rate     <= csr_wdata[16:0];
            REG_SPEED_LIMIT:     cfg_ff.speed_limit     <= csr_wdata;
            REG_ANGLE_PER_PULSE: cfg_ff.angle_per_pulse <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

endmodule

@@ hw/rtl/ptcl_mul.sv @@
// ----------------------------------------------------------------------------
// ptcl_mul
// Shared multi-cycle multiplier: 32 x 48 bit unsigned, one 32 x 16 partial
// product per cycle, accumulated LSB digit first with a right shift.
// ----------------------------------------------------------------------------
module ptcl_mul
   import ptcl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [31:0]     op_a,
   input  logic [47:0]     op_b,
   output unit_status_type status,
   output logic [79:0]     product
);

   logic [31:0] a_ff;
   logic [47:0] b_ff;
   logic [79:0] p_ff;
   logic [1:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [47:0] pp;
   logic [47:0] sum;

   // upper partial plus new digit product always fits 48 bits
   assign pp  = a_ff * b_ff[MUL_DIGIT-1:0];
   assign sum = {16'd0, p_ff[79:48]} + pp;

   assign status  = '{busy: busy_ff, done: done_ff};
   assign product = p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 2'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'(MUL_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
         p_ff <= '0;
      end else if (busy_ff) begin
         p_ff <= {sum, p_ff[47:16]};
         b_ff <= {16'd0, b_ff[47:16]};
      end
   end

endmodule

@@ hw/rtl/ptcl_div.sv @@
// ----------------------------------------------------------------------------
// ptcl_div
// Restoring divider, 36-bit dividend by 24-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module ptcl_div
   import ptcl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [35:0]     dividend,
   input  logic [23:0]     divisor,
   output unit_status_type status,
   output logic [35:0]     quotient
);

   logic [23:0] rem_ff;
   logic [35:0] quo_ff;
   logic [23:0] dvs_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [24:0] trial;
   logic [24:0] diff;
   logic        ge;

   assign trial = {rem_ff, quo_ff[35]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = trial >= {1'b0, dvs_ff};

   assign status   = '{busy: busy_ff, done: done_ff};
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // remainder stays below the divisor, so 24 bits hold it
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[23:0] : trial[23:0];
         quo_ff <= {quo_ff[34:0], ge};
      end
   end

endmodule

@@ hw/rtl/pi_torque_current_loop.sv @@
// ----------------------------------------------------------------------------
// pi_torque_current_loop
// Current-sense filter, torque PI controller and shaft speed estimate, one
// control tick per request, built around one shared multiplier and a
// bit-serial divider.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake             Payload
// req_      in   req_valid/req_ready   sample, elapsed, pulse period, cmd, on
// rsp_      out  rsp_valid/rsp_ready   duty, dir_a/dir_b, enable, speed
// csr_      in   csr_valid/csr_ready   3-bit index, 32-bit write data
//
// Active tick (motor on, below speed limit): its length is set by the 36-step
// divider; the six multiplies in the shared 32x16 multiplier run beside it.
// When the pulse period is 0 the divider is not started.
// Inactive tick: no arithmetic runs; held values are returned.
// req_ready is high only when the sequencer is idle; one finished response may
// wait in the output register while the next request is accepted.
// Reset is synchronous: registers return to defaults, state clears, dir = 1.
// csr writes are taken every cycle (csr_ready is tied high).
// ----------------------------------------------------------------------------
module pi_torque_current_loop
   import ptcl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_current_sample,
   input  logic [15:0] req_elapsed_us,
   input  logic [23:0] req_pulse_period_us,
   input  logic signed [31:0] req_torque_command,
   input  logic        req_motor_on,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [16:0] rsp_duty,
   output logic        rsp_dir_a,
   output logic        rsp_dir_b,
   output logic        rsp_drive_enable,
   output logic [31:0] rsp_shaft_speed,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,   // waiting for a request
      S_LOAD = 5'b00010,   // drive multiplier operands for the current phase
      S_MULW = 5'b00100,   // wait for the product, then fold it into state
      S_DIVW = 5'b01000,   // wait for the speed quotient
      S_FIN  = 5'b10000    // hand the result to the output register
   } state_type;

   // multiply phases of an active tick, in order
   typedef enum logic [2:0] {
      PH_RAW  = 3'd0,   // |sample - offset| * scale
      PH_GAIN = 3'd1,   // filter_rate * elapsed
      PH_FILT = 3'd2,   // gain * |raw - filt|
      PH_TORQ = 3'd3,   // torque_constant * filt
      PH_PROP = 3'd4,   // Kp * |err|
      PH_INTG = 3'd5    // Ki * |integ|
   } phase_type;

   cfg_type         cfg;
   unit_status_type mul_st;
   unit_status_type div_st;
   logic [79:0]     prod;
   logic [35:0]     quo;

   state_type   state_ff;
   phase_type   phase_ff;

   // latched request fields
   logic [11:0] sample_ff;
   logic [15:0] elapsed_ff;
   logic [31:0] abs_cmd_ff;
   logic        dir_new_ff;
   logic        per_zero_ff;
   logic        active_ff;

   // intermediates of the tick
   logic [19:0] raw_ff;
   logic [16:0] gain_ff;
   logic [32:0] err_ff;     // two's complement
   logic [47:0] pterm_ff;   // two's complement

   // loop state
   logic [19:0] filt_ff;
   logic [47:0] integ_ff;   // two's complement
   logic [31:0] speed_ff;
   logic [16:0] held_duty_ff;
   logic        held_dir_ff;

   // response register
   logic        rsp_valid_ff;
   logic [16:0] rsp_duty_ff;
   logic        rsp_dir_ff;
   logic        rsp_en_ff;
   logic [31:0] rsp_speed_ff;

   // next values and operands
   logic        act_in;
   logic [31:0] abs_cmd_in;
   logic        div_start;
   logic        mul_start;
   logic        fin_go;
   logic [31:0] op_a;
   logic [47:0] op_b;
   logic [11:0] sense_diff;
   logic [20:0] dsub;
   logic [19:0] dmag;
   logic [32:0] err_mag;
   logic [47:0] integ_mag;
   logic [19:0] raw_in;
   logic [16:0] gain_in;
   logic [19:0] step;
   logic [19:0] filt_in;
   logic [27:0] torque;
   logic [32:0] err_in;
   logic [48:0] integ_sum;
   logic [47:0] integ_in;
   logic [47:0] pmag;
   logic [47:0] pterm_in;
   logic [62:0] imag;
   logic [63:0] iterm;
   logic [64:0] duty_sum;
   logic [16:0] duty_in;
   logic [31:0] speed_in;

   ptcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ptcl_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (op_a),
      .op_b    (op_b),
      .status  (mul_st),
      .product (prod)
   );

   ptcl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({cfg.angle_per_pulse, 16'd0}),
      .divisor  (req_pulse_period_us),
      .status   (div_st),
      .quotient (quo)
   );

   // ---------------------------------------------------------------- request
   assign req_ready = (state_ff == S_IDLE);

   // trip test: speed < limit << 16 is the same as speed >> 16 < limit
   assign act_in = req_motor_on && ({16'd0, speed_ff[31:16]} < cfg.speed_limit);

   // most negative command maps to 2^31, which 32 unsigned bits hold
   assign abs_cmd_in = req_torque_command[31] ? (~req_torque_command + 32'd1)
                                              : req_torque_command;

   // speed division starts with the request and runs beside the multiplies
   assign div_start = req_valid && req_ready && act_in && (req_pulse_period_us != 24'd0);
   assign mul_start = (state_ff == S_LOAD);
   assign fin_go    = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   // ------------------------------------------------------------- operands
   always_comb begin
      sense_diff = (sample_ff >= cfg.sense_offset) ? sample_ff - cfg.sense_offset
                                                   : cfg.sense_offset - sample_ff;
      dsub      = {1'b0, raw_ff} - {1'b0, filt_ff};
      dmag      = dsub[20] ? 20'(~dsub + 21'd1) : dsub[19:0];
      err_mag   = err_ff[32] ? (~err_ff + 33'd1) : err_ff;
      integ_mag = integ_ff[47] ? (~integ_ff + 48'd1) : integ_ff;

      op_a = '0;
      op_b = '0;
      unique case (phase_ff)
         PH_RAW: begin
            op_a = {8'd0, cfg.sense_scale};
            op_b = {36'd0, sense_diff};
         end
         PH_GAIN: begin
            op_a = {15'd0, cfg.filter_rate};
            op_b = {32'd0, elapsed_ff};
         end
         PH_FILT: begin
            op_a = {15'd0, gain_ff};
            op_b = {28'd0, dmag};
         end
         PH_TORQ: begin
            op_a = {8'd0, cfg.torque_constant};
            op_b = {28'd0, filt_ff};
         end
         PH_PROP: begin
            op_a = {1'b0, cfg.prop_gain};
            op_b = {16'd0, err_mag[31:0]};
         end
         PH_INTG: begin
            op_a = {1'b0, cfg.integ_gain};
            op_b = integ_mag;
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------- product folding
   always_comb begin
      // current in Q16.16, clamped to 10 A
      raw_in  = (prod[35:12] > {4'd0, CURRENT_MAX}) ? CURRENT_MAX : prod[31:12];
      gain_in = (prod[32:0] > {16'd0, Q_ONE}) ? Q_ONE : prod[16:0];

      // filter moves toward raw without overshoot, so 20 bits hold it
      step    = prod[35:16];
      filt_in = dsub[20] ? filt_ff - step : filt_ff + step;

      torque  = prod[43:16];
      err_in  = {1'b0, abs_cmd_ff} - {5'd0, torque};

      // saturating 48-bit integral
      integ_sum = {integ_ff[47], integ_ff} + {{16{err_in[32]}}, err_in};
      if (integ_sum[48] != integ_sum[47]) begin
         integ_in = integ_sum[48] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integ_in = integ_sum[47:0];
      end

      // products truncate toward zero: scale the magnitude, reapply sign
      pmag     = prod[63:16];
      pterm_in = err_ff[32] ? (~pmag + 48'd1) : pmag;
      imag     = prod[78:16];
      iterm    = integ_ff[47] ? (~{1'b0, imag} + 64'd1) : {1'b0, imag};
      duty_sum = {{17{pterm_ff[47]}}, pterm_ff} + {iterm[63], iterm};
      if (duty_sum[64]) begin
         duty_in = '0;
      end else if (duty_sum[63:0] > {47'd0, Q_ONE}) begin
         duty_in = Q_ONE;
      end else begin
         duty_in = duty_sum[16:0];
      end

      if (per_zero_ff) begin
         speed_in = '0;
      end else if (quo[35:32] != 4'd0) begin
         speed_in = '1;
      end else begin
         speed_in = quo[31:0];
      end
   end

   // ------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_RAW;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         filt_ff      <= '0;
         integ_ff     <= '0;
         speed_ff     <= '0;
         held_duty_ff <= '0;
         held_dir_ff  <= 1'b1;
      end else begin
         // a new result may replace one taken on the same edge
         if (fin_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  active_ff <= act_in;
                  phase_ff  <= PH_RAW;
                  state_ff  <= act_in ? S_LOAD : S_FIN;
               end
            end
            S_LOAD: begin
               state_ff <= S_MULW;
            end
            S_MULW: begin
               if (mul_st.done) begin
                  unique case (phase_ff)
                     PH_RAW: begin
                        phase_ff <= PH_GAIN;
                        state_ff <= S_LOAD;
                     end
                     PH_GAIN: begin
                        phase_ff <= PH_FILT;
                        state_ff <= S_LOAD;
                     end
                     PH_FILT: begin
                        filt_ff  <= filt_in;
                        phase_ff <= PH_TORQ;
                        state_ff <= S_LOAD;
                     end
                     PH_TORQ: begin
                        integ_ff <= integ_in;
                        phase_ff <= PH_PROP;
                        state_ff <= S_LOAD;
                     end
                     PH_PROP: begin
                        phase_ff <= PH_INTG;
                        state_ff <= S_LOAD;
                     end
                     PH_INTG: begin
                        held_duty_ff <= duty_in;
                        held_dir_ff  <= dir_new_ff;
                        state_ff     <= S_DIVW;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_DIVW: begin
               if (!div_st.busy) begin
                  speed_ff <= speed_in;
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (fin_go) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff   <= req_current_sample;
         elapsed_ff  <= req_elapsed_us;
         abs_cmd_ff  <= abs_cmd_in;
         dir_new_ff  <= ~req_torque_command[31];
         per_zero_ff <= (req_pulse_period_us == 24'd0);
      end
      if ((state_ff == S_MULW) && mul_st.done) begin
         case (phase_ff)
            PH_RAW:  raw_ff   <= raw_in;
            PH_GAIN: gain_ff  <= gain_in;
            PH_TORQ: err_ff   <= err_in;
            PH_PROP: pterm_ff <= pterm_in;
            default: ;
         endcase
      end
      if (fin_go) begin
         rsp_duty_ff  <= held_duty_ff;
         rsp_dir_ff   <= held_dir_ff;
         rsp_en_ff    <= active_ff;
         rsp_speed_ff <= speed_ff;
      end
   end

   // -------------------------------------------------------------- response
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_duty         = rsp_duty_ff;
   assign rsp_dir_a        = rsp_dir_ff;
   assign rsp_dir_b        = ~rsp_dir_ff;
   assign rsp_drive_enable = rsp_en_ff;
   assign rsp_shaft_speed  = rsp_speed_ff;

`ifndef NO_ASSERTIONS
   // multiplier finishes only while the sequencer waits on it
   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_st.done |-> (state_ff == S_MULW))
      else $error("multiplier done outside of product wait");

   // speed quotient is complete before the response is formed
   a_div_idle_at_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> !div_st.busy)
      else $error("divider still busy at response");

   // both arithmetic units are quiet whenever a request can be taken
   a_units_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!mul_st.busy && !div_st.busy))
      else $error("arithmetic unit busy while idle");

   // a request with the motor off skips all arithmetic
   a_off_skips: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_motor_on) |=> (state_ff == S_FIN))
      else $error("motor-off request entered the arithmetic sequence");
`endif

endmodule
